[hdl/sobet_pkg.sv]
`timescale 1ns / 1ps
// shared widths, constants, register codes and tap arithmetic for the sobel edge block
package sobet_pkg;

  localparam int PIX_W   = 8;    // grayscale pixel
  localparam int CFG_W   = 11;   // geometry register width
  localparam int THR_W   = 8;    // threshold register width
  localparam int MAG_W   = 8;    // magnitude field width
  localparam int TERM_W  = 11;   // signed pixel times coefficient
  localparam int SUM_W   = 10;   // signed running tap sum
  localparam int VAL_W   = 14;   // signed sum in eighths plus term

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int MIN_DIM        = 3;
  localparam int RST_WIDTH      = 1024;
  localparam int RST_HEIGHT     = 1024;
  localparam int RST_THRESHOLD  = 50;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_EDGE_THRESHOLD = 2'd2
  } cfg_reg_e;

  // pixel times a coefficient of magnitude one or two
  function automatic logic signed [TERM_W-1:0] px_term(input logic [PIX_W-1:0] p,
                                                       input logic neg,
                                                       input logic dbl);
    logic signed [TERM_W-1:0] m;
    m = dbl ? signed'({2'b00, p, 1'b0}) : signed'({3'b000, p});
    return neg ? -m : m;
  endfunction

  // one tap: term counts in eighths, new sum truncated toward zero
  function automatic logic signed [SUM_W-1:0] tap_step(input logic signed [SUM_W-1:0] sum,
                                                       input logic signed [TERM_W-1:0] term);
    logic signed [VAL_W-1:0] v;
    logic signed [VAL_W-1:0] q;
    v = (VAL_W'(sum) <<< 3) + VAL_W'(term);
    q = v >>> 3;
    if (v[VAL_W-1] && (v[2:0] != 3'b000)) begin
      q = q + VAL_W'(1);
    end
    return SUM_W'(q);
  endfunction

endpackage

[hdl/sobet_ram.sv]
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module sobet_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hdl/sobel_edge_threshold.sv]
`timescale 1ns / 1ps
// sobel edge detector top level: line store, window, tap pipeline and threshold
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------------
//   in      | in        | in_valid_i / in_stall_o | pixel_i
//   out     | out       | out_valid_o/ out_stall_i| edge_res_o magnitude_o column_index_o
//           |           |                         | row_index_o
//   cfg     | in        | cfg_valid_i/ cfg_ready_o| cfg_index_i cfg_data_i
//
// one pixel item per clock while in_stall_o is low; an interior result passes the three tap
// stages and then the output stage before it leaves the output register
// the line store ram is read ahead at the next column, so its read latency is hidden
// reset clears counters, window taps and pipeline valids, and loads default geometry; the line
// store is not cleared, its stale entries only feed the first two rows, which give no result
// out_stall_i holds the output register; stages behind it keep filling bubbles, and
// in_stall_o rises only when the first tap stage holds an item that cannot move
module sobel_edge_threshold #(
  parameter int MAX_WIDTH  = sobet_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sobet_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // pixel input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [sobet_pkg::PIX_W-1:0]     pixel_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            edge_res_o,
  output logic [sobet_pkg::MAG_W-1:0]     magnitude_o,
  output logic [$clog2(MAX_WIDTH)-1:0]    column_index_o,
  output logic [$clog2(MAX_HEIGHT)-1:0]   row_index_o,
  // register writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_index_i,
  input  logic [sobet_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int PW = sobet_pkg::PIX_W;
  localparam int SW = sobet_pkg::SUM_W;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  // width of the clamped geometry values, wide enough for the raw field and the maximum
  localparam int WW = (sobet_pkg::CFG_W > $clog2(MAX_WIDTH + 1)) ?
                      sobet_pkg::CFG_W : $clog2(MAX_WIDTH + 1);
  localparam int HW = (sobet_pkg::CFG_W > $clog2(MAX_HEIGHT + 1)) ?
                      sobet_pkg::CFG_W : $clog2(MAX_HEIGHT + 1);
  localparam int WIDTH_RST  = (sobet_pkg::RST_WIDTH > MAX_WIDTH) ?
                              MAX_WIDTH : sobet_pkg::RST_WIDTH;
  localparam int HEIGHT_RST = (sobet_pkg::RST_HEIGHT > MAX_HEIGHT) ?
                              MAX_HEIGHT : sobet_pkg::RST_HEIGHT;

  // ---------------------------------------------------------------------------------------
  // configuration: geometry is stored already clamped to its legal range
  // ---------------------------------------------------------------------------------------
  logic [WW-1:0]                   width_q;
  logic [HW-1:0]                   height_q;
  logic [sobet_pkg::THR_W-1:0]     thr_q;
  logic                            cfg_we;
  logic [WW-1:0]                   cfg_w_ext;
  logic [HW-1:0]                   cfg_h_ext;
  logic [WW-1:0]                   width_clamped;
  logic [HW-1:0]                   height_clamped;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_w_ext   = WW'(cfg_data_i);
  assign cfg_h_ext   = HW'(cfg_data_i);

  always_comb begin
    if (cfg_w_ext < WW'(sobet_pkg::MIN_DIM)) begin
      width_clamped = WW'(sobet_pkg::MIN_DIM);
    end else if (cfg_w_ext > WW'(MAX_WIDTH)) begin
      width_clamped = WW'(MAX_WIDTH);
    end else begin
      width_clamped = cfg_w_ext;
    end
    if (cfg_h_ext < HW'(sobet_pkg::MIN_DIM)) begin
      height_clamped = HW'(sobet_pkg::MIN_DIM);
    end else if (cfg_h_ext > HW'(MAX_HEIGHT)) begin
      height_clamped = HW'(MAX_HEIGHT);
    end else begin
      height_clamped = cfg_h_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(WIDTH_RST);
      height_q <= HW'(HEIGHT_RST);
      thr_q    <= sobet_pkg::THR_W'(sobet_pkg::RST_THRESHOLD);
    end else if (cfg_we) begin
      case (cfg_index_i)
        sobet_pkg::REG_IMAGE_WIDTH:    width_q  <= width_clamped;
        sobet_pkg::REG_IMAGE_HEIGHT:   height_q <= height_clamped;
        sobet_pkg::REG_EDGE_THRESHOLD: thr_q    <= cfg_data_i[sobet_pkg::THR_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // pipeline handshake: each stage loads when empty or when its item moves on
  // ---------------------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic load_s1, load_s2, load_s3, load_out;
  logic in_accept;

  assign load_out   = !out_valid_q || !out_stall_i;
  assign load_s3    = !s3_valid_q  || load_out;
  assign load_s2    = !s2_valid_q  || load_s3;
  assign load_s1    = !s1_valid_q  || load_s2;
  assign in_stall_o = !load_s1;
  assign in_accept  = in_valid_i && load_s1;

  // ---------------------------------------------------------------------------------------
  // raster position of the arriving pixel
  // ---------------------------------------------------------------------------------------
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          col_wrap;
  logic          row_wrap;
  logic          interior;

  assign col_wrap = (WW'(col_q) + WW'(1)) >= width_q;
  assign row_wrap = (HW'(row_q) + HW'(1)) >= height_q;
  assign interior = (col_q >= CW'(2)) && (row_q >= RW'(2));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_accept) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------------------
  // line store: one entry per column holds {line two above, line above}
  // read ahead at the next column so the data is ready when the pixel arrives;
  // the entry written is never the one being read in the same or next cycle
  // ---------------------------------------------------------------------------------------
  logic [2*PW-1:0] ram_rdata;
  logic [2*PW-1:0] ram_wdata;
  logic [PW-1:0]   up2_px;   // column c, two lines above
  logic [PW-1:0]   up1_px;   // column c, one line above

  assign up2_px    = ram_rdata[2*PW-1:PW];
  assign up1_px    = ram_rdata[PW-1:0];
  assign ram_wdata = {up1_px, pixel_i};

  sobet_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (col_q),
    .wdata_i (ram_wdata),
    .raddr_i (col_d),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------------------
  // window taps: per window row, [0] holds column c-2 and [1] holds column c-1
  // ---------------------------------------------------------------------------------------
  logic [PW-1:0] taps_q [6];
  logic [PW-1:0] new_col [3];

  assign new_col[0] = up2_px;
  assign new_col[1] = up1_px;
  assign new_col[2] = pixel_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        taps_q[i] <= '0;
      end
    end else if (in_accept) begin
      for (int i = 0; i < 3; i++) begin
        taps_q[2*i]     <= taps_q[2*i+1];
        taps_q[2*i + 1] <= new_col[i];
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // stage 1: captured window (center tap has zero weight in both kernels)
  // ---------------------------------------------------------------------------------------
  logic [PW-1:0] s1_p00_q, s1_p01_q, s1_p02_q, s1_p10_q, s1_p12_q;
  logic [PW-1:0] s1_p20_q, s1_p21_q, s1_p22_q;
  logic [CW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (load_s1) begin
      s1_valid_q <= in_accept && interior;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_s1 && in_accept) begin
      s1_p00_q <= taps_q[0];
      s1_p01_q <= taps_q[1];
      s1_p02_q <= up2_px;
      s1_p10_q <= taps_q[2];
      s1_p12_q <= up1_px;
      s1_p20_q <= taps_q[4];
      s1_p21_q <= taps_q[5];
      s1_p22_q <= pixel_i;
      s1_col_q <= col_q - CW'(1);
      s1_row_q <= row_q - RW'(1);
    end
  end

  // first three nonzero taps of each kernel, in scan order
  logic signed [SW-1:0] gx_a1, gx_a2, gx_a3;
  logic signed [SW-1:0] gy_a1, gy_a2, gy_a3;

  always_comb begin
    gx_a1 = sobet_pkg::tap_step('0,    sobet_pkg::px_term(s1_p00_q, 1'b1, 1'b0));
    gx_a2 = sobet_pkg::tap_step(gx_a1, sobet_pkg::px_term(s1_p02_q, 1'b0, 1'b0));
    gx_a3 = sobet_pkg::tap_step(gx_a2, sobet_pkg::px_term(s1_p10_q, 1'b1, 1'b1));
    gy_a1 = sobet_pkg::tap_step('0,    sobet_pkg::px_term(s1_p00_q, 1'b1, 1'b0));
    gy_a2 = sobet_pkg::tap_step(gy_a1, sobet_pkg::px_term(s1_p01_q, 1'b1, 1'b1));
    gy_a3 = sobet_pkg::tap_step(gy_a2, sobet_pkg::px_term(s1_p02_q, 1'b1, 1'b0));
  end

  // ---------------------------------------------------------------------------------------
  // stage 2: partial sums plus remaining taps
  // ---------------------------------------------------------------------------------------
  logic signed [SW-1:0] s2_gx_q, s2_gy_q;
  logic [PW-1:0]        s2_p12_q, s2_p20_q, s2_p21_q, s2_p22_q;
  logic [CW-1:0]        s2_col_q;
  logic [RW-1:0]        s2_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (load_s2) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_s2 && s1_valid_q) begin
      s2_gx_q  <= gx_a3;
      s2_gy_q  <= gy_a3;
      s2_p12_q <= s1_p12_q;
      s2_p20_q <= s1_p20_q;
      s2_p21_q <= s1_p21_q;
      s2_p22_q <= s1_p22_q;
      s2_col_q <= s1_col_q;
      s2_row_q <= s1_row_q;
    end
  end

  logic signed [SW-1:0] gx_b1, gx_b2, gx_b3;
  logic signed [SW-1:0] gy_b1, gy_b2, gy_b3;

  always_comb begin
    gx_b1 = sobet_pkg::tap_step(s2_gx_q, sobet_pkg::px_term(s2_p12_q, 1'b0, 1'b1));
    gx_b2 = sobet_pkg::tap_step(gx_b1,   sobet_pkg::px_term(s2_p20_q, 1'b1, 1'b0));
    gx_b3 = sobet_pkg::tap_step(gx_b2,   sobet_pkg::px_term(s2_p22_q, 1'b0, 1'b0));
    gy_b1 = sobet_pkg::tap_step(s2_gy_q, sobet_pkg::px_term(s2_p20_q, 1'b0, 1'b0));
    gy_b2 = sobet_pkg::tap_step(gy_b1,   sobet_pkg::px_term(s2_p21_q, 1'b0, 1'b1));
    gy_b3 = sobet_pkg::tap_step(gy_b2,   sobet_pkg::px_term(s2_p22_q, 1'b0, 1'b0));
  end

  // ---------------------------------------------------------------------------------------
  // stage 3: final gradients
  // ---------------------------------------------------------------------------------------
  logic signed [SW-1:0] s3_gx_q, s3_gy_q;
  logic [CW-1:0]        s3_col_q;
  logic [RW-1:0]        s3_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (load_s3) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_s3 && s2_valid_q) begin
      s3_gx_q  <= gx_b3;
      s3_gy_q  <= gy_b3;
      s3_col_q <= s2_col_q;
      s3_row_q <= s2_row_q;
    end
  end

  // l1 magnitude; the threshold compare is made in the output register
  logic [SW-1:0]                abs_gx, abs_gy;
  logic [SW:0]                  mag_full;
  logic [sobet_pkg::MAG_W-1:0]  mag;

  assign abs_gx   = s3_gx_q[SW-1] ? SW'(-s3_gx_q) : SW'(s3_gx_q);
  assign abs_gy   = s3_gy_q[SW-1] ? SW'(-s3_gy_q) : SW'(s3_gy_q);
  assign mag_full = {1'b0, abs_gx} + {1'b0, abs_gy};
  assign mag      = mag_full[sobet_pkg::MAG_W-1:0];

  // ---------------------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------------------
  logic                         edge_q;
  logic [sobet_pkg::MAG_W-1:0]  mag_q;
  logic [CW-1:0]                out_col_q;
  logic [RW-1:0]                out_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out && s3_valid_q) begin
      edge_q    <= mag > thr_q;
      mag_q     <= mag;
      out_col_q <= s3_col_q;
      out_row_q <= s3_row_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign edge_res_o     = edge_q;
  assign magnitude_o    = mag_q;
  assign column_index_o = out_col_q;
  assign row_index_o    = out_row_q;

`ifndef SYNTH
  // border pixels never enter the tap pipeline
  a_border_no_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !interior) |=> !s1_valid_q)
    else $error("border pixel produced a pipeline item");

  // row advances only on a column wrap
  a_row_on_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !col_wrap) |=> $stable(row_q))
    else $error("row counter moved without column wrap");

  // last stage keeps its item while the output register is held
  a_s3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && !load_out) |=> (s3_valid_q && $stable(s3_gx_q) && $stable(s3_gy_q)))
    else $error("stage 3 item lost under output stall");

  // results describe interior centers only
  a_interior_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_col_q != '0) && (out_row_q != '0)))
    else $error("result on a border center");
`endif

endmodule
